>>> hdl/mexp_pkg.sv
package mexp_pkg;

    localparam int MAX_WORDS   = 64;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = $clog2(MAX_WORDS);
    localparam int CNT_W       = $clog2(MAX_WORDS + 1);
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        ACT_BASE  = 2'd0,
        ACT_EXP   = 2'd1,
        ACT_MOD   = 2'd2,
        ACT_START = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PASS, S_ZDEC, S_ZOUT,
        S_BFET, S_BCAP, S_BBIT, S_BDBL, S_BNEXT,
        S_EFET, S_ECAP, S_EBIT, S_ESQD, S_ENEXT,
        S_MFET, S_MCAP, S_MBIT, S_MDBL, S_MNEXT,
        S_ORD, S_OCAP, S_OHOLD
    } t_state;

    typedef enum logic [1:0] {
        PK_ADD, PK_COPY, PK_ZCHK
    } t_pkind;

    typedef enum logic [2:0] {
        YS_R, YS_A, YS_B, YS_ONE, YS_ZERO
    } t_ysrc;

    typedef enum logic [1:0] {
        DST_R, DST_A, DST_B
    } t_dst;

    typedef struct packed {
        logic   go;
        t_pkind kind;
        t_ysrc  ys;
        t_dst   dst;
        t_state ret;
    } t_pass_req;

endpackage

>>> hdl/mexp_ram.sv
module mexp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/modular_exponentiation_unit.sv
// modular exponentiation, left-to-right square and multiply
// input stream (s side): one item per accepted beat; tuser is the action
// (load base word, load exponent word, load modulus word, start)
// loads are taken one per cycle and write the operand stores directly
// a start computes base^exponent mod modulus over word_count words (0 taken
// as 1, above 64 taken as 64) and then sends word_count result items on the
// m side, low word first, tlast on the final one; an all-zero modulus gives a
// single zero item with tuser set
// all arithmetic runs word serial out of synchronous rams: one add/subtract
// pass runs over all n words and every modular doubling or addition
// is one pass, so with n words:
//   zero check one pass, base reduction 2048 bits x 1..2 passes,
//   each modular product a clearing pass, 32n bits x 1..2 passes and a copy pass,
//   one or two products per exponent bit below the top set bit,
//   each result item read, captured and held, then a clearing sweep of the stores
// the input side is not ready during a run; a stalled receiver simply holds
// the current result item until it is taken
// after reset the same clearing sweep runs before the first item
module modular_exponentiation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // word_index[5:0], data_word[37:6], word_count[44:38], zero pad
    input  logic [mexp_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // action[1:0]
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // result_word[31:0], result_index[37:32], zero pad
    output logic [mexp_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // last_word
    output logic                              o_m_tlast,
    // zero_modulus
    output logic                              o_m_tuser
);

    localparam int WW = mexp_pkg::WORD_W;
    localparam int IW = mexp_pkg::IDX_W;
    localparam int CW = mexp_pkg::CNT_W;
    localparam int BW = mexp_pkg::BIT_W;

    // control state
    mexp_pkg::t_state r_state, n_state;
    mexp_pkg::t_state r_ret, n_ret;
    mexp_pkg::t_state r_mret, n_mret;
    mexp_pkg::t_pkind r_pk, n_pk;
    mexp_pkg::t_ysrc  r_ys, n_ys;
    mexp_pkg::t_ysrc  r_my, n_my;
    mexp_pkg::t_dst   r_dst, n_dst;
    mexp_pkg::t_pass_req req;

    logic [IW-1:0] r_ci, n_ci;          // clearing sweep index
    logic [CW-1:0] r_n, n_n;            // effective word count
    logic [CW-1:0] r_pi, n_pi;          // pass issue counter
    logic          r_c, n_c;            // add carry
    logic          r_b, n_b;            // subtract borrow
    logic          r_mnz, n_mnz;        // modulus nonzero
    logic          r_p, n_p;            // bank holding the running value
    logic          r_sel, n_sel;        // 1: running value in difference ram
    logic [IW-1:0] r_ow, n_ow;          // base / exponent word
    logic [IW-1:0] r_mw, n_mw;          // multiplier word
    logic [BW-1:0] r_bit, n_bit;
    logic [BW-1:0] r_ebit, n_ebit;
    logic [WW-1:0] r_word, n_word;
    logic [WW-1:0] r_eword, n_eword;
    logic          r_started, n_started;
    logic [CW-1:0] r_k, n_k;            // result word counter

    // output register
    logic          r_ov, n_ov;
    logic [WW-1:0] r_oword, n_oword;
    logic [IW-1:0] r_oidx, n_oidx;
    logic          r_olast, n_olast;
    logic          r_ozm, n_ozm;

    // input unpacking
    logic                  in_acc;
    mexp_pkg::t_action     in_act;
    logic [IW-1:0]         in_idx;
    logic [WW-1:0]         in_data;
    logic [CW-1:0]         in_wc;
    logic [CW-1:0]         wc_clamped;

    assign o_s_tready = (r_state == mexp_pkg::S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign in_act     = mexp_pkg::t_action'(i_s_tuser);
    assign in_idx     = i_s_tdata[IW-1:0];
    assign in_data    = i_s_tdata[IW+WW-1:IW];
    assign in_wc      = i_s_tdata[IW+WW+CW-1:IW+WW];

    always_comb begin
        if (in_wc == '0) begin
            wc_clamped = CW'(1);
        end else if (in_wc > CW'(mexp_pkg::MAX_WORDS)) begin
            wc_clamped = CW'(mexp_pkg::MAX_WORDS);
        end else begin
            wc_clamped = in_wc;
        end
    end

    // memories
    logic [WW-1:0] base_rd, exp_rd, mod_rd, a_rd, b_rd, s_rd, d_rd;
    logic          clr;
    logic          ops_we_base, ops_we_exp, ops_we_mod;
    logic [IW-1:0] ops_waddr;
    logic [WW-1:0] ops_wdata;
    logic [IW-1:0] a_raddr;
    logic          sd_we, a_we, b_we;
    logic [IW:0]   sd_raddr, sd_waddr;
    logic [WW-1:0] s_wdata, d_wdata;

    // pass datapath
    logic          p_proc, pass_end;
    logic [CW-1:0] pi_m1;
    logic [IW-1:0] w_idx;
    logic [WW-1:0] x_w, y_w;
    logic [WW:0]   sum33, diff33;

    assign clr         = (r_state == mexp_pkg::S_CLEAR);
    assign ops_we_base = clr || (in_acc && in_act == mexp_pkg::ACT_BASE);
    assign ops_we_exp  = clr || (in_acc && in_act == mexp_pkg::ACT_EXP);
    assign ops_we_mod  = clr || (in_acc && in_act == mexp_pkg::ACT_MOD);
    assign ops_waddr   = clr ? r_ci : in_idx;
    assign ops_wdata   = clr ? '0 : in_data;

    assign p_proc   = (r_state == mexp_pkg::S_PASS) && (r_pi != '0);
    assign pass_end = (r_state == mexp_pkg::S_PASS) && (r_pi == r_n);
    assign pi_m1    = r_pi - CW'(1);
    assign w_idx    = pi_m1[IW-1:0];

    assign x_w = r_sel ? d_rd : s_rd;

    always_comb begin
        case (r_ys)
            mexp_pkg::YS_R:   y_w = x_w;
            mexp_pkg::YS_A:   y_w = a_rd;
            mexp_pkg::YS_B:   y_w = b_rd;
            mexp_pkg::YS_ONE: y_w = (w_idx == '0) ? WW'(1) : '0;
            default:          y_w = '0;
        endcase
    end

    assign sum33  = (WW+1)'(x_w) + (WW+1)'(y_w) + (WW+1)'(r_c);
    assign diff33 = (WW+1)'(sum33[WW-1:0]) - (WW+1)'(mod_rd) - (WW+1)'(r_b);

    assign sd_raddr = {r_p, r_pi[IW-1:0]};
    assign sd_waddr = {~r_p, w_idx};
    assign sd_we    = p_proc && (r_pk == mexp_pkg::PK_ADD ||
                                 (r_pk == mexp_pkg::PK_COPY && r_dst == mexp_pkg::DST_R));
    assign s_wdata  = (r_pk == mexp_pkg::PK_ADD) ? sum33[WW-1:0] : y_w;
    assign d_wdata  = (r_pk == mexp_pkg::PK_ADD) ? diff33[WW-1:0] : y_w;
    assign a_we     = p_proc && r_pk == mexp_pkg::PK_COPY && r_dst == mexp_pkg::DST_A;
    assign b_we     = p_proc && r_pk == mexp_pkg::PK_COPY && r_dst == mexp_pkg::DST_B;

    always_comb begin
        if (r_state == mexp_pkg::S_MFET) begin
            a_raddr = r_mw;
        end else if (r_state == mexp_pkg::S_ORD) begin
            a_raddr = r_k[IW-1:0];
        end else begin
            a_raddr = r_pi[IW-1:0];
        end
    end

    mexp_ram #(.WIDTH(WW), .DEPTH(mexp_pkg::MAX_WORDS)) u_base_ram (
        .i_clk(i_clk), .i_we(ops_we_base), .i_waddr(ops_waddr), .i_wdata(ops_wdata),
        .i_raddr(r_ow), .o_rdata(base_rd)
    );

    mexp_ram #(.WIDTH(WW), .DEPTH(mexp_pkg::MAX_WORDS)) u_exp_ram (
        .i_clk(i_clk), .i_we(ops_we_exp), .i_waddr(ops_waddr), .i_wdata(ops_wdata),
        .i_raddr(r_ow), .o_rdata(exp_rd)
    );

    mexp_ram #(.WIDTH(WW), .DEPTH(mexp_pkg::MAX_WORDS)) u_mod_ram (
        .i_clk(i_clk), .i_we(ops_we_mod), .i_waddr(ops_waddr), .i_wdata(ops_wdata),
        .i_raddr(r_pi[IW-1:0]), .o_rdata(mod_rd)
    );

    // accumulator
    mexp_ram #(.WIDTH(WW), .DEPTH(mexp_pkg::MAX_WORDS)) u_acc_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(w_idx), .i_wdata(y_w),
        .i_raddr(a_raddr), .o_rdata(a_rd)
    );

    // reduced base
    mexp_ram #(.WIDTH(WW), .DEPTH(mexp_pkg::MAX_WORDS)) u_bred_ram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(w_idx), .i_wdata(y_w),
        .i_raddr(r_pi[IW-1:0]), .o_rdata(b_rd)
    );

    // running value: sum and sum minus modulus, two banks each
    mexp_ram #(.WIDTH(WW), .DEPTH(2 * mexp_pkg::MAX_WORDS)) u_sum_ram (
        .i_clk(i_clk), .i_we(sd_we), .i_waddr(sd_waddr), .i_wdata(s_wdata),
        .i_raddr(sd_raddr), .o_rdata(s_rd)
    );

    mexp_ram #(.WIDTH(WW), .DEPTH(2 * mexp_pkg::MAX_WORDS)) u_diff_ram (
        .i_clk(i_clk), .i_we(sd_we), .i_waddr(sd_waddr), .i_wdata(d_wdata),
        .i_raddr(sd_raddr), .o_rdata(d_rd)
    );

    // pass requests (fsm outputs)
    always_comb begin
        req.go   = 1'b0;
        req.kind = mexp_pkg::PK_ADD;
        req.ys   = mexp_pkg::YS_R;
        req.dst  = mexp_pkg::DST_R;
        req.ret  = mexp_pkg::S_IDLE;
        unique case (r_state)
            mexp_pkg::S_IDLE: begin
                if (in_acc && in_act == mexp_pkg::ACT_START) begin
                    req.go   = 1'b1;
                    req.kind = mexp_pkg::PK_ZCHK;
                    req.ret  = mexp_pkg::S_ZDEC;
                end
            end
            mexp_pkg::S_ZDEC: begin
                // clear the running value before base reduction
                if (r_mnz) begin
                    req.go   = 1'b1;
                    req.kind = mexp_pkg::PK_COPY;
                    req.ys   = mexp_pkg::YS_ZERO;
                    req.ret  = mexp_pkg::S_BFET;
                end
            end
            mexp_pkg::S_BBIT: begin
                req.go  = 1'b1;
                req.ret = mexp_pkg::S_BDBL;
            end
            mexp_pkg::S_BDBL: begin
                if (r_word[r_bit]) begin
                    req.go  = 1'b1;
                    req.ys  = mexp_pkg::YS_ONE;
                    req.ret = mexp_pkg::S_BNEXT;
                end
            end
            mexp_pkg::S_BNEXT: begin
                if (r_bit == '0 && r_ow == '0) begin
                    req.go   = 1'b1;
                    req.kind = mexp_pkg::PK_COPY;
                    req.dst  = mexp_pkg::DST_B;
                    req.ret  = mexp_pkg::S_EFET;
                end
            end
            mexp_pkg::S_EBIT: begin
                if (r_started) begin
                    // square: clear running value, then multiply
                    req.go   = 1'b1;
                    req.kind = mexp_pkg::PK_COPY;
                    req.ys   = mexp_pkg::YS_ZERO;
                    req.ret  = mexp_pkg::S_MFET;
                end else if (r_eword[r_ebit]) begin
                    // top set bit: accumulator takes the reduced base
                    req.go   = 1'b1;
                    req.kind = mexp_pkg::PK_COPY;
                    req.dst  = mexp_pkg::DST_A;
                    req.ret  = mexp_pkg::S_ENEXT;
                end
            end
            mexp_pkg::S_ESQD: begin
                if (r_eword[r_ebit]) begin
                    req.go   = 1'b1;
                    req.kind = mexp_pkg::PK_COPY;
                    req.ys   = mexp_pkg::YS_ZERO;
                    req.ret  = mexp_pkg::S_MFET;
                end
            end
            mexp_pkg::S_ENEXT: begin
                // exponent all zero: result is one
                if (r_ebit == '0 && r_ow == '0 && !r_started) begin
                    req.go   = 1'b1;
                    req.kind = mexp_pkg::PK_COPY;
                    req.ys   = mexp_pkg::YS_ONE;
                    req.dst  = mexp_pkg::DST_A;
                    req.ret  = mexp_pkg::S_ORD;
                end
            end
            mexp_pkg::S_MBIT: begin
                req.go  = 1'b1;
                req.ret = mexp_pkg::S_MDBL;
            end
            mexp_pkg::S_MDBL: begin
                if (r_word[r_bit]) begin
                    req.go  = 1'b1;
                    req.ys  = r_my;
                    req.ret = mexp_pkg::S_MNEXT;
                end
            end
            mexp_pkg::S_MNEXT: begin
                if (r_bit == '0 && r_mw == '0) begin
                    req.go   = 1'b1;
                    req.kind = mexp_pkg::PK_COPY;
                    req.dst  = mexp_pkg::DST_A;
                    req.ret  = r_mret;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (req.go) begin
            n_state = mexp_pkg::S_PASS;
        end else begin
            unique case (r_state)
                mexp_pkg::S_CLEAR: begin
                    if (r_ci == IW'(mexp_pkg::MAX_WORDS - 1)) n_state = mexp_pkg::S_IDLE;
                end
                mexp_pkg::S_IDLE:  n_state = mexp_pkg::S_IDLE;
                mexp_pkg::S_PASS: begin
                    if (pass_end) n_state = r_ret;
                end
                mexp_pkg::S_ZDEC:  n_state = mexp_pkg::S_ZOUT;
                mexp_pkg::S_ZOUT: begin
                    if (i_m_tready) n_state = mexp_pkg::S_CLEAR;
                end
                mexp_pkg::S_BFET:  n_state = mexp_pkg::S_BCAP;
                mexp_pkg::S_BCAP:  n_state = mexp_pkg::S_BBIT;
                mexp_pkg::S_BBIT:  n_state = mexp_pkg::S_BDBL;
                mexp_pkg::S_BDBL:  n_state = mexp_pkg::S_BNEXT;
                mexp_pkg::S_BNEXT: begin
                    n_state = (r_bit == '0) ? mexp_pkg::S_BFET : mexp_pkg::S_BBIT;
                end
                mexp_pkg::S_EFET:  n_state = mexp_pkg::S_ECAP;
                mexp_pkg::S_ECAP:  n_state = mexp_pkg::S_EBIT;
                mexp_pkg::S_EBIT:  n_state = mexp_pkg::S_ENEXT;
                mexp_pkg::S_ESQD:  n_state = mexp_pkg::S_ENEXT;
                mexp_pkg::S_ENEXT: begin
                    if (r_ebit != '0) begin
                        n_state = mexp_pkg::S_EBIT;
                    end else if (r_ow != '0) begin
                        n_state = mexp_pkg::S_EFET;
                    end else begin
                        n_state = mexp_pkg::S_ORD;
                    end
                end
                mexp_pkg::S_MFET:  n_state = mexp_pkg::S_MCAP;
                mexp_pkg::S_MCAP:  n_state = mexp_pkg::S_MBIT;
                mexp_pkg::S_MBIT:  n_state = mexp_pkg::S_MDBL;
                mexp_pkg::S_MDBL:  n_state = mexp_pkg::S_MNEXT;
                mexp_pkg::S_MNEXT: begin
                    n_state = (r_bit == '0) ? mexp_pkg::S_MFET : mexp_pkg::S_MBIT;
                end
                mexp_pkg::S_ORD:   n_state = mexp_pkg::S_OCAP;
                mexp_pkg::S_OCAP:  n_state = mexp_pkg::S_OHOLD;
                mexp_pkg::S_OHOLD: begin
                    if (i_m_tready) n_state = r_olast ? mexp_pkg::S_CLEAR : mexp_pkg::S_ORD;
                end
                default:           n_state = mexp_pkg::S_CLEAR;
            endcase
        end
    end

    // datapath next values
    always_comb begin
        n_ci      = r_ci;
        n_n       = r_n;
        n_pi      = r_pi;
        n_c       = r_c;
        n_b       = r_b;
        n_mnz     = r_mnz;
        n_p       = r_p;
        n_sel     = r_sel;
        n_ow      = r_ow;
        n_mw      = r_mw;
        n_bit     = r_bit;
        n_ebit    = r_ebit;
        n_word    = r_word;
        n_eword   = r_eword;
        n_started = r_started;
        n_k       = r_k;
        n_ret     = r_ret;
        n_mret    = r_mret;
        n_pk      = r_pk;
        n_ys      = r_ys;
        n_my      = r_my;
        n_dst     = r_dst;
        n_ov      = r_ov;
        n_oword   = r_oword;
        n_oidx    = r_oidx;
        n_olast   = r_olast;
        n_ozm     = r_ozm;

        case (r_state)
            mexp_pkg::S_CLEAR: n_ci = r_ci + IW'(1);
            mexp_pkg::S_IDLE: begin
                if (in_acc && in_act == mexp_pkg::ACT_START) n_n = wc_clamped;
            end
            mexp_pkg::S_PASS: begin
                n_pi = r_pi + CW'(1);
                if (p_proc) begin
                    if (r_pk == mexp_pkg::PK_ADD) begin
                        n_c = sum33[WW];
                        n_b = diff33[WW];
                    end else if (r_pk == mexp_pkg::PK_ZCHK) begin
                        n_mnz = r_mnz | (|mod_rd);
                    end
                end
                if (pass_end) begin
                    if (r_pk == mexp_pkg::PK_ADD) begin
                        // take the difference when sum reached the modulus
                        n_p   = ~r_p;
                        n_sel = sum33[WW] | ~diff33[WW];
                    end else if (r_pk == mexp_pkg::PK_COPY && r_dst == mexp_pkg::DST_R) begin
                        n_p   = ~r_p;
                        n_sel = 1'b0;
                    end
                end
            end
            mexp_pkg::S_ZDEC: begin
                n_ow = IW'(mexp_pkg::MAX_WORDS - 1);
                if (!r_mnz) begin
                    n_ov    = 1'b1;
                    n_oword = '0;
                    n_oidx  = '0;
                    n_olast = 1'b1;
                    n_ozm   = 1'b1;
                end
            end
            mexp_pkg::S_ZOUT: begin
                if (i_m_tready) n_ov = 1'b0;
            end
            mexp_pkg::S_BCAP: begin
                n_word = base_rd;
                n_bit  = BW'(WW - 1);
            end
            mexp_pkg::S_BNEXT: begin
                if (r_bit != '0) begin
                    n_bit = r_bit - BW'(1);
                end else if (r_ow != '0) begin
                    n_ow = r_ow - IW'(1);
                end else begin
                    n_ow      = IW'(mexp_pkg::MAX_WORDS - 1);
                    n_started = 1'b0;
                end
            end
            mexp_pkg::S_ECAP: begin
                n_eword = exp_rd;
                n_ebit  = BW'(WW - 1);
            end
            mexp_pkg::S_EBIT: begin
                if (r_started) begin
                    n_my   = mexp_pkg::YS_A;
                    n_mret = mexp_pkg::S_ESQD;
                    n_mw   = pi_last();
                end else if (r_eword[r_ebit]) begin
                    n_started = 1'b1;
                end
            end
            mexp_pkg::S_ESQD: begin
                if (r_eword[r_ebit]) begin
                    n_my   = mexp_pkg::YS_B;
                    n_mret = mexp_pkg::S_ENEXT;
                    n_mw   = pi_last();
                end
            end
            mexp_pkg::S_ENEXT: begin
                if (r_ebit != '0) begin
                    n_ebit = r_ebit - BW'(1);
                end else if (r_ow != '0) begin
                    n_ow = r_ow - IW'(1);
                end else begin
                    n_k = '0;
                end
            end
            mexp_pkg::S_MCAP: begin
                n_word = a_rd;
                n_bit  = BW'(WW - 1);
            end
            mexp_pkg::S_MNEXT: begin
                if (r_bit != '0) begin
                    n_bit = r_bit - BW'(1);
                end else if (r_mw != '0) begin
                    n_mw = r_mw - IW'(1);
                end
            end
            mexp_pkg::S_OCAP: begin
                n_ov    = 1'b1;
                n_oword = a_rd;
                n_oidx  = r_k[IW-1:0];
                n_olast = (r_k == r_n - CW'(1));
                n_ozm   = 1'b0;
            end
            mexp_pkg::S_OHOLD: begin
                if (i_m_tready) begin
                    n_ov = 1'b0;
                    n_k  = r_k + CW'(1);
                end
            end
            default: begin
            end
        endcase

        if (req.go) begin
            n_pi  = '0;
            n_pk  = req.kind;
            n_ys  = req.ys;
            n_dst = req.dst;
            n_ret = req.ret;
            n_c   = 1'b0;
            n_b   = 1'b0;
            n_mnz = 1'b0;
        end
    end

    // top word index of the operands in use
    function automatic logic [IW-1:0] pi_last();
        logic [CW-1:0] t;
        t = r_n - CW'(1);
        return t[IW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mexp_pkg::S_CLEAR;
            r_ci      <= '0;
            r_pi      <= '0;
            r_p       <= 1'b0;
            r_sel     <= 1'b0;
            r_started <= 1'b0;
            r_ov      <= 1'b0;
            r_n       <= CW'(1);
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_ci      <= n_ci;
            r_pi      <= n_pi;
            r_p       <= n_p;
            r_sel     <= n_sel;
            r_started <= n_started;
            r_ov      <= n_ov;
            r_n       <= n_n;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_b     <= n_b;
        r_mnz   <= n_mnz;
        r_ow    <= n_ow;
        r_mw    <= n_mw;
        r_bit   <= n_bit;
        r_ebit  <= n_ebit;
        r_word  <= n_word;
        r_eword <= n_eword;
        r_ret   <= n_ret;
        r_mret  <= n_mret;
        r_pk    <= n_pk;
        r_ys    <= n_ys;
        r_my    <= n_my;
        r_dst   <= n_dst;
        r_oword <= n_oword;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
        r_ozm   <= n_ozm;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {(mexp_pkg::OUT_TDATA_W - WW - IW)'(0), r_oidx, r_oword};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ozm;

    // a result item is only shown from the two hold states
    a_ov_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_state == mexp_pkg::S_OHOLD || r_state == mexp_pkg::S_ZOUT))
        else $error("result valid outside hold state");

    // no new item accepted while a result is pending
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_ov)
        else $error("input ready with result pending");

    // pass counter never runs past the word count
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::S_PASS) |-> (r_pi <= r_n))
        else $error("pass counter overrun");

    // the zero modulus item stands alone
    a_zero_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ozm) |-> (r_olast && r_oidx == '0))
        else $error("zero modulus item not single");

    // stores are swept after the final item of a run
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_m_tready && r_olast) |=> (r_state == mexp_pkg::S_CLEAR))
        else $error("no clearing sweep after run");

endmodule
